>>> design/ale_pkg.sv
// Shared types and constants for the array list engine.
`timescale 1ns / 1ps

package ale_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int ACT_W  = 3;
   localparam int POS_W  = 8;
   localparam int STAT_W = 3;

   // action codes
   localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ_ALL  = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd4;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_MATCH,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [CNT_W-1:0]         pos;
      logic [CNT_W-1:0]         cnt;
      logic signed [DATA_W-1:0] data;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_READ
   } state_type;

endpackage

>>> design/ale_cell.sv
// One list cell: holds one entry, shifts with its neighbors, compares for delete.
`timescale 1ns / 1ps

module ale_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ale_pkg::cell_ctrl_type            ctrl,
   input  logic signed [ale_pkg::DATA_W-1:0] left_value,
   input  logic signed [ale_pkg::DATA_W-1:0] right_value,
   input  logic                              seen,
   output logic signed [ale_pkg::DATA_W-1:0] value,
   output logic                              match
);

   localparam logic [ale_pkg::CNT_W-1:0] IDX_V  = ale_pkg::CNT_W'(INDEX);
   localparam logic [ale_pkg::CNT_W-1:0] NEXT_V = ale_pkg::CNT_W'(INDEX + 1);

   logic signed [ale_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      unique case (ctrl.op)
         ale_pkg::CELL_HOLD: begin
         end
         ale_pkg::CELL_INSERT: begin
            if (IDX_V == ctrl.pos) begin
               value_in = ctrl.data;
            end else if (IDX_V > ctrl.pos && IDX_V <= ctrl.cnt) begin
               value_in = left_value;
            end
         end
         ale_pkg::CELL_MATCH: begin
            match_in = (IDX_V < ctrl.cnt) && (value_ff == ctrl.data);
         end
         ale_pkg::CELL_DELETE: begin
            if (seen && NEXT_V < ctrl.cnt) begin
               value_in = right_value;
            end
         end
         ale_pkg::CELL_ROTATE: begin
            if (NEXT_V < ctrl.cnt) begin
               value_in = right_value;
            end else if (NEXT_V == ctrl.cnt) begin
               value_in = ctrl.data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

>>> design/ale_match_scan.sv
// Prefix OR over the cell match flags and position of the first match.
`timescale 1ns / 1ps

module ale_match_scan #(
   parameter int N = 64
) (
   input  logic [N-1:0]               match,
   output logic [N-1:0]               seen,
   output logic                       found,
   output logic [ale_pkg::IDX_W-1:0]  first_index
);

   localparam int LEVELS = $clog2(N);

   logic [N-1:0] lvl [0:LEVELS];
   logic [N-1:0] first;

   always_comb begin
      lvl[0] = match;
      for (int k = 0; k < LEVELS; k++) begin
         for (int i = 0; i < N; i++) begin
            if (i >= (1 << k)) begin
               lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
            end else begin
               lvl[k+1][i] = lvl[k][i];
            end
         end
      end
   end

   assign seen  = lvl[LEVELS];
   assign found = lvl[LEVELS][N-1];
   assign first = lvl[LEVELS] & ~(lvl[LEVELS] << 1);

   always_comb begin
      first_index = '0;
      for (int i = 0; i < N; i++) begin
         if (first[i]) begin
            first_index = first_index | ale_pkg::IDX_W'(i);
         end
      end
   end

endmodule

>>> design/array_list_engine_top.sv
// Top level of the array list engine: command decode, cell chain and result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells.
// A command is taken when start is high and busy is low. Inserts, clear and
// every refused or invalid command finish in the EXEC state; a delete passes
// through EXEC, where all cells compare, and SCAN, where the tail shifts down;
// read all passes through EXEC and then READ, one entry a cycle as the chain
// rotates past cell 0. Each result sits on the rsp_ ports for exactly one
// cycle with rsp_valid high and cannot be held off; rsp_last marks the final
// result of a command, and busy is already low in that cycle.

module array_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ale_pkg::ACT_W-1:0]          req_action,
   input  logic signed [ale_pkg::DATA_W-1:0]  req_value,
   input  logic [ale_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   output logic [ale_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ale_pkg::DATA_W-1:0]  rsp_data,
   output logic [ale_pkg::IDX_W-1:0]          rsp_index,
   output logic [ale_pkg::CNT_W-1:0]          rsp_count,
   output logic                               rsp_last
);

   localparam logic [ale_pkg::CNT_W-1:0] CAP_V = ale_pkg::CNT_W'(CAPACITY);

   ale_pkg::state_type                 state_ff, state_in;
   logic [ale_pkg::ACT_W-1:0]          action_ff, action_in;
   logic signed [ale_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [ale_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [ale_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [ale_pkg::IDX_W-1:0]          rd_idx_ff, rd_idx_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ale_pkg::STAT_W-1:0]         rsp_status_ff, rsp_status_in;
   logic signed [ale_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [ale_pkg::IDX_W-1:0]          rsp_index_ff, rsp_index_in;
   logic [ale_pkg::CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                               rsp_last_ff, rsp_last_in;

   ale_pkg::cell_ctrl_type             ctrl;
   logic signed [ale_pkg::DATA_W-1:0]  cell_value [CAPACITY];
   logic [CAPACITY-1:0]                cell_match;
   logic [CAPACITY-1:0]                seen;
   logic                               found;
   logic [ale_pkg::IDX_W-1:0]          first_index;
   logic [ale_pkg::CNT_W-1:0]          ins_pos;
   logic [ale_pkg::CNT_W-1:0]          rd_next;

   // clamp insert position to the current count
   assign ins_pos = ({1'b0, count_ff} <= pos_ff) ? count_ff
                                                 : pos_ff[ale_pkg::CNT_W-1:0];
   assign rd_next = ale_pkg::CNT_W'(rd_idx_ff) + ale_pkg::CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ale_pkg::STAT_OK;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_count_in  = count_ff;
      rsp_last_in   = 1'b1;
      ctrl.op       = ale_pkg::CELL_HOLD;
      ctrl.pos      = ins_pos;
      ctrl.cnt      = count_ff;
      ctrl.data     = value_ff;

      unique case (state_ff)
         ale_pkg::ST_IDLE: begin
            if (start) begin
               action_in = req_action;
               value_in  = req_value;
               pos_in    = req_position;
               state_in  = ale_pkg::ST_EXEC;
            end
         end
         ale_pkg::ST_EXEC: begin
            state_in     = ale_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (action_ff)
               ale_pkg::ACT_INS_FRONT, ale_pkg::ACT_INS_BACK, ale_pkg::ACT_INS_POS: begin
                  if (count_ff == CAP_V) begin
                     rsp_status_in = ale_pkg::STAT_FULL;
                  end else begin
                     ctrl.op = ale_pkg::CELL_INSERT;
                     if (action_ff == ale_pkg::ACT_INS_FRONT) begin
                        ctrl.pos = '0;
                     end else if (action_ff == ale_pkg::ACT_INS_BACK) begin
                        ctrl.pos = count_ff;
                     end
                     count_in     = count_ff + ale_pkg::CNT_W'(1);
                     rsp_count_in = count_in;
                  end
               end
               ale_pkg::ACT_DELETE: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ale_pkg::STAT_EMPTY;
                  end else begin
                     ctrl.op      = ale_pkg::CELL_MATCH;
                     rsp_valid_in = 1'b0;
                     state_in     = ale_pkg::ST_SCAN;
                  end
               end
               ale_pkg::ACT_CLEAR: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ale_pkg::STAT_EMPTY;
                  end else begin
                     count_in     = '0;
                     rsp_count_in = '0;
                  end
               end
               ale_pkg::ACT_READ_ALL: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ale_pkg::STAT_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     rd_idx_in    = '0;
                     state_in     = ale_pkg::ST_READ;
                  end
               end
               default: begin
                  rsp_status_in = ale_pkg::STAT_INVALID;
               end
            endcase
         end
         ale_pkg::ST_SCAN: begin
            state_in     = ale_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            if (found) begin
               ctrl.op      = ale_pkg::CELL_DELETE;
               count_in     = count_ff - ale_pkg::CNT_W'(1);
               rsp_count_in = count_in;
               rsp_data_in  = value_ff;
               rsp_index_in = first_index;
            end else begin
               rsp_status_in = ale_pkg::STAT_NOT_FOUND;
            end
         end
         ale_pkg::ST_READ: begin
            // rotate the occupied cells so the next entry reaches cell 0
            ctrl.op      = ale_pkg::CELL_ROTATE;
            ctrl.data    = cell_value[0];
            rsp_valid_in = 1'b1;
            rsp_data_in  = cell_value[0];
            rsp_index_in = rd_idx_ff;
            rsp_last_in  = (rd_next == count_ff);
            rd_idx_in    = rd_next[ale_pkg::IDX_W-1:0];
            if (rd_next == count_ff) begin
               state_in = ale_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ale_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ale_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [ale_pkg::DATA_W-1:0] left_v;
      logic signed [ale_pkg::DATA_W-1:0] right_v;

      if (g == 0) begin : g_head
         assign left_v = '0;
      end else begin : g_body_l
         assign left_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_body_r
         assign right_v = cell_value[g+1];
      end

      ale_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .seen        (seen[g]),
         .value       (cell_value[g]),
         .match       (cell_match[g])
      );
   end

   ale_match_scan #(
      .N (CAPACITY)
   ) u_scan (
      .match       (cell_match),
      .seen        (seen),
      .found       (found),
      .first_index (first_index)
   );

   assign busy       = (state_ff != ale_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> design/ale_checker.sv
// Port-level checks for the array list engine, bound to the top level.
`timescale 1ns / 1ps

module ale_checker #(
   parameter int CAPACITY = 64
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [ale_pkg::STAT_W-1:0]        rsp_status,
   input logic [ale_pkg::CNT_W-1:0]         rsp_count,
   input logic                              rsp_last
);

   localparam logic [ale_pkg::CNT_W-1:0] CAP_V = ale_pkg::CNT_W'(CAPACITY);

   // an accepted transaction always makes the engine busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("engine not busy after accepting a transaction");

   // reported count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CAP_V)
      else $error("reported count above capacity");

   // a read-all stream has no gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a read-all stream");

   // error results are always single and final
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ale_pkg::STAT_OK |-> rsp_last)
      else $error("error result not marked last");

   // final result comes with the engine ready for the next transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy during final result");

endmodule

bind array_list_engine_top ale_checker #(
   .CAPACITY (CAPACITY)
) u_ale_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count),
   .rsp_last   (rsp_last)
);
